/* design/jam_pkg.sv */
package jam_pkg;
  localparam int WindowDef = 160;
  localparam int FullScale = 32767;
  localparam int RateLimit = 262144;
  localparam logic [6:0] AxisEvent = 7'd2;
  localparam int CmdEvent = 0;
  localparam int CmdPoll  = 1;
  localparam int PosW  = 16;
  localparam int GainW = 18;
  localparam int RateW = 20;
  localparam int SumW  = 26;
  localparam int ProdW = SumW + GainW;
  localparam int QuoW  = ProdW;

  localparam logic [2:0] RegFwdAxis  = 3'd0;
  localparam logic [2:0] RegSideAxis = 3'd1;
  localparam logic [2:0] RegTurnAxis = 3'd2;
  localparam logic [2:0] RegFwdGain  = 3'd3;
  localparam logic [2:0] RegSideGain = 3'd4;
  localparam logic [2:0] RegTurnGain = 3'd5;

  typedef struct packed {
    logic             start;
    logic [SumW-1:0]  sum;
    logic [GainW-1:0] gain;
    logic [31:0]      den;
  } div_req_t;
endpackage

/* design/jam_serdiv.sv */
// Bit-serial unit: shift-add multiply then restoring divide, one bit per cycle.
module jam_serdiv
  import jam_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  div_req_t                req,
  output logic                    busy,
  output logic                    done,
  output logic signed [RateW-1:0] rate
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_DIV  = 3'b100
  } st_t;

  st_t              st_r, st_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [ProdW-1:0] acc_r, acc_nxt;
  logic [GainW-1:0] mq_r, mq_nxt;
  logic [ProdW-1:0] mcand_r, mcand_nxt;
  logic [32:0]      rem_r, rem_nxt;
  logic [31:0]      den_r, den_nxt;
  logic             done_r, done_nxt;
  logic [32:0]      trial;
  logic [QuoW-1:0]  q;
  logic [SumW-1:0]  mag;

  assign mag   = req.sum[SumW-1] ? (~req.sum + 1'b1) : req.sum;
  assign trial = {rem_r[31:0], acc_r[ProdW-1]} - {1'b0, den_r};

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; neg_nxt = neg_r; acc_nxt = acc_r;
    mq_nxt = mq_r; mcand_nxt = mcand_r; rem_nxt = rem_r; den_nxt = den_r;
    done_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (req.start) begin
          neg_nxt = req.sum[SumW-1];
          mcand_nxt = ProdW'(mag);
          mq_nxt = req.gain;
          den_nxt = req.den;
          acc_nxt = '0;
          cnt_nxt = 7'(GainW);
          st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mq_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt = mcand_r << 1;
        mq_nxt = mq_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          st_nxt = S_DIV;
          cnt_nxt = 7'(ProdW);
          rem_nxt = '0;
        end
      end
      S_DIV: begin
        if (!trial[32]) begin
          rem_nxt = trial;
          acc_nxt = {acc_r[ProdW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], acc_r[ProdW-1]};
          acc_nxt = {acc_r[ProdW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          st_nxt = S_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    neg_r <= neg_nxt; acc_r <= acc_nxt; mq_r <= mq_nxt; mcand_r <= mcand_nxt;
    rem_r <= rem_nxt; den_r <= den_nxt;
  end

  // quotient magnitude; sign flips since result is minus the mean
  assign q = acc_r;
  always_comb begin
    if (q >= QuoW'(RateLimit)) rate = neg_r ? RateW'(RateLimit) : -RateW'(RateLimit);
    else rate = neg_r ? RateW'(q) : -RateW'(q);
  end
  assign busy = (st_r != S_IDLE);
  assign done = done_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy) else $error("start while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy) else $error("done while busy");
`endif
endmodule

/* design/joystick_axis_moving_average_unit.sv */
// Joystick moving-average unit.
// in_ stream: each beat is either an event (tuser=0) or a poll tick (tuser=1).
// An axis event latches its position into every channel whose configured
// axis matches; it produces no output beat.
// A poll tick pushes the three held positions into a WINDOW-deep history
// (one memory read and one write), updates three running sums and produces
// one out_ beat carrying minus mean * gain / 32767 per channel, Q15.
// The three channels share one bit-serial multiply/divide unit, taking them in
// turn: 18 multiply steps and 44 divide steps per channel.
// in_tready is low from the poll tick beat until its result is loaded into
// the output register, which raises out_tvalid; no beat is taken meanwhile.
// Results wait in an output register: events are taken while it is full,
// a finished tick holds until the register frees; out_tdata stays put
// while the receiver stalls.
// Reset clears held positions, sums, fill count and pointer, and restores
// the configuration registers to their defaults; the history memory is
// not cleared (it is never read before written).
// cfg_: APB-style, registers at 4*i, pready always high.
module joystick_axis_moving_average_unit
  import jam_pkg::*;
#(
  parameter int WINDOW = WindowDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // event_type[7:0], axis_index[15:8], axis_position[31:16]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // forward_rate[19:0], sideways_rate[39:20], turn_rate[59:40]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  typedef enum logic [5:0] {
    P_IDLE = 6'b000001, P_RD = 6'b000010, P_UPD = 6'b000100,
    P_CH   = 6'b001000, P_WT = 6'b010000, P_OUT = 6'b100000
  } ph_t;

  ph_t              ph_r;
  logic [7:0]       axis_r [3];
  logic [GainW-1:0] gain_r [3];
  logic signed [PosW-1:0] held_r [3];
  logic signed [SumW-1:0] sum_r [3];
  logic [CW-1:0]    fill_r;
  logic [AW-1:0]    old_r, slot_r;
  logic [3*PosW-1:0] mem [WINDOW];
  logic [3*PosW-1:0] rd_r;
  logic [1:0]       ch_r;
  logic [RateW-1:0] res_r [3];
  logic [31:0]      den_r;
  div_req_t         req;
  logic             busy, done;
  logic [RateW-1:0] rate;
  logic             full, acc_in, cfg_wr;
  logic [CW:0]      sp;
  logic [2:0]       ridx;
  logic             out_v_r;
  logic [63:0]      out_r;
  logic             out_ld;

  assign full   = (fill_r == CW'(WINDOW));
  assign acc_in = in_tvalid && in_tready;
  assign in_tready = (ph_r == P_IDLE);
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx = cfg_paddr[4:2];
  assign sp = {1'b0, old_r} + {1'b0, fill_r};
  assign out_ld = (ph_r == P_OUT) && (!out_v_r || out_tready);

  always_comb begin
    case (ridx)
      RegFwdAxis:  cfg_prdata = 32'(axis_r[0]);
      RegSideAxis: cfg_prdata = 32'(axis_r[1]);
      RegTurnAxis: cfg_prdata = 32'(axis_r[2]);
      RegFwdGain:  cfg_prdata = 32'(gain_r[0]);
      RegSideGain: cfg_prdata = 32'(gain_r[1]);
      RegTurnGain: cfg_prdata = 32'(gain_r[2]);
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r[0] <= 8'd1; axis_r[1] <= 8'd0; axis_r[2] <= 8'd3;
      gain_r[0] <= 18'd6554; gain_r[1] <= 18'd3277; gain_r[2] <= 18'd205887;
    end else if (cfg_wr) begin
      case (ridx)
        RegFwdAxis:  axis_r[0] <= cfg_pwdata[7:0];
        RegSideAxis: axis_r[1] <= cfg_pwdata[7:0];
        RegTurnAxis: axis_r[2] <= cfg_pwdata[7:0];
        RegFwdGain:  gain_r[0] <= cfg_pwdata[GainW-1:0];
        RegSideGain: gain_r[1] <= cfg_pwdata[GainW-1:0];
        RegTurnGain: gain_r[2] <= cfg_pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ph_r == P_RD) rd_r <= mem[slot_r];
    if (ph_r == P_UPD) mem[slot_r] <= {held_r[2], held_r[1], held_r[0]};
  end

  always_comb begin
    req.start = (ph_r == P_CH);
    req.sum   = sum_r[ch_r];
    req.gain  = gain_r[ch_r];
    req.den   = den_r;
  end

  jam_serdiv u_div (.clk, .rst_n, .req, .busy, .done, .rate);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_IDLE;
      fill_r <= '0; old_r <= '0; ch_r <= '0;
      for (int c = 0; c < 3; c++) begin held_r[c] <= '0; sum_r[c] <= '0; end
    end else begin
      case (ph_r)
        P_IDLE: if (acc_in) begin
          if (in_tuser == 1'(CmdPoll)) begin
            ph_r <= P_RD;
            slot_r <= full ? old_r
                    : (sp >= (CW+1)'(WINDOW) ? AW'(sp - (CW+1)'(WINDOW)) : AW'(sp));
          end else if (in_tdata[6:0] == AxisEvent) begin
            for (int c = 0; c < 3; c++)
              if (axis_r[c] == in_tdata[15:8]) held_r[c] <= in_tdata[31:16];
          end
        end
        P_RD: ph_r <= P_UPD;
        P_UPD: begin
          for (int c = 0; c < 3; c++)
            sum_r[c] <= sum_r[c] + SumW'(held_r[c])
              - (full ? SumW'($signed(rd_r[c*PosW +: PosW])) : SumW'(0));
          if (full) old_r <= (slot_r == AW'(WINDOW-1)) ? '0 : slot_r + 1'b1;
          else fill_r <= fill_r + 1'b1;
          den_r <= 32'((full ? fill_r : fill_r + 1'b1)) * 32'(FullScale);
          ch_r <= '0;
          ph_r <= P_CH;
        end
        P_CH: ph_r <= P_WT;
        P_WT: if (done) begin
          res_r[ch_r] <= rate;
          if (ch_r == 2'd2) ph_r <= P_OUT;
          else begin ch_r <= ch_r + 1'b1; ph_r <= P_CH; end
        end
        P_OUT: if (out_ld) ph_r <= P_IDLE;
        default: ph_r <= P_IDLE;
      endcase
    end
  end

  // output register frees the input side while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ld) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (out_ld) out_r <= {4'd0, res_r[2], res_r[1], res_r[0]};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

`ifndef ASSERT_OFF
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(WINDOW)) else $error("fill over window");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> old_r == '0) else $error("pointer moved early");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped while stalled");
  a_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == P_WT) && !done |-> busy) else $error("divider idle while waited on");
`endif
endmodule
